@@ rtl/core/sm3_pkg.sv @@
`default_nettype none
package sm3_pkg;

  localparam logic [31:0] T_LOW  = 32'h79cc4519;
  localparam logic [31:0] T_HIGH = 32'h7a879d8a;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [3:0]  LEN_SLOT = 4'd14;
  localparam int unsigned NUM_IV = 8;

  localparam logic [255:0] IV_RESET = {
    32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
    32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_COMP,
    ST_PAD,
    ST_OUT
  } sm3_state_t;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_LEN_HI,
    SRC_LEN_LO
  } pad_src_t;

  // controller to datapath
  typedef struct packed {
    logic     load_iv;
    logic     take_word;
    logic     push_pad;
    pad_src_t pad_src;
    logic     comp_start;
    logic     comp_step;
  } sm3_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic       block_full;
    logic [3:0] fill;
    logic       comp_last;
    logic       extra_pad;
  } sm3_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
    logic [63:0] d;
    d = {x, x} << n;
    return d[63:32];
  endfunction

  function automatic logic [31:0] perm0(input logic [31:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [31:0] perm1(input logic [31:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/sm3_ctrl.sv @@
`default_nettype none
module sm3_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              in_last,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [2:0]             out_idx,
  output sm3_pkg::sm3_cmd_t      cmd,
  input  wire sm3_pkg::sm3_sts_t sts
);
  import sm3_pkg::*;

  sm3_state_t state_r, state_nxt;
  logic       busy_r, busy_nxt;
  logic       final_r, final_nxt;
  logic       lenhi_r, lenhi_nxt;
  logic [2:0] oidx_r, oidx_nxt;
  logic       acc;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_idx   = oidx_r;
  assign acc       = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      busy_r  <= 1'b0;
      final_r <= 1'b0;
      lenhi_r <= 1'b0;
      oidx_r  <= '0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
      final_r <= final_nxt;
      lenhi_r <= lenhi_nxt;
      oidx_r  <= oidx_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    busy_nxt  = busy_r;
    final_nxt = final_r;
    lenhi_nxt = lenhi_r;
    oidx_nxt  = oidx_r;
    cmd       = '0;
    cmd.pad_src = SRC_ZERO;
    case (state_r)
      ST_IDLE: begin
        if (acc) begin
          cmd.load_iv   = !busy_r;
          cmd.take_word = 1'b1;
          busy_nxt      = !in_last;
          final_nxt     = in_last;
          lenhi_nxt     = 1'b0;
          if (sts.block_full) begin
            cmd.comp_start = 1'b1;
            state_nxt      = ST_COMP;
          end else if (in_last) begin
            state_nxt = ST_PAD;
          end
        end
      end
      ST_COMP: begin
        cmd.comp_step = 1'b1;
        if (sts.comp_last) begin
          if (!final_r) begin
            state_nxt = ST_IDLE;
          end else if (!lenhi_r) begin
            state_nxt = ST_PAD;
          end else begin
            state_nxt = ST_OUT;
            lenhi_nxt = 1'b0;
            oidx_nxt  = '0;
          end
        end
      end
      ST_PAD: begin
        cmd.push_pad = 1'b1;
        if (sts.extra_pad) begin
          cmd.pad_src = SRC_ZERO;
        end else if (sts.fill == LEN_SLOT) begin
          cmd.pad_src = SRC_LEN_HI;
          lenhi_nxt   = 1'b1;
        end else if (lenhi_r) begin
          cmd.pad_src = SRC_LEN_LO;
        end else begin
          cmd.pad_src = SRC_ZERO;
        end
        if (sts.block_full) begin
          cmd.comp_start = 1'b1;
          state_nxt      = ST_COMP;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            state_nxt = ST_IDLE;
            final_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

@@ rtl/core/sm3_datapath.sv @@
`default_nettype none
module sm3_datapath (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [255:0]      iv,
  input  wire logic [31:0]       in_msg_word,
  input  wire logic [2:0]        in_byte_count,
  input  wire logic              in_last,
  input  wire logic [2:0]        out_idx,
  output logic [31:0]            out_word,
  input  wire sm3_pkg::sm3_cmd_t cmd,
  output sm3_pkg::sm3_sts_t      sts
);
  import sm3_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] cv_r [8];
  logic [31:0] rr_r [8];
  logic [63:0] len_r, len_nxt;
  logic [3:0]  fill_r, fill_nxt;
  logic [5:0]  rnd_r;
  logic        xpad_r, xpad_nxt;

  logic [2:0]  nb;
  logic [31:0] mask, pword, push_val;
  logic        do_push, second;

  // word pushed this cycle
  always_comb begin
    nb = (in_byte_count > 3'd4) ? 3'd4 : in_byte_count;
    if (!in_last) nb = 3'd4;
    mask  = (nb == 3'd0) ? 32'd0 : (32'hffffffff << (6'd32 - {nb, 3'b000}));
    pword = (in_msg_word & mask) | ({24'd0, PAD_BYTE} << (5'd24 - {nb[1:0], 3'b000}));
    second = 1'b0;
    do_push = cmd.take_word | cmd.push_pad;
    if (cmd.take_word)
      push_val = (in_last && nb != 3'd4) ? pword : in_msg_word;
    else if (xpad_r)
      push_val = {PAD_BYTE, 24'd0};
    else begin
      case (cmd.pad_src)
        SRC_LEN_HI: push_val = len_r[63:32];
        SRC_LEN_LO: push_val = len_r[31:0];
        default:    push_val = 32'd0;
      endcase
    end
    fill_nxt = do_push ? fill_r + 4'd1 : fill_r;
    if (cmd.load_iv && cmd.take_word) fill_nxt = 4'd1;
    len_nxt = cmd.load_iv ? 64'd0 : len_r;
    if (cmd.take_word) len_nxt = len_nxt + {58'd0, nb, 3'b000};
    xpad_nxt = xpad_r;
    if (cmd.take_word) xpad_nxt = in_last && nb == 3'd4;
    else if (cmd.push_pad) xpad_nxt = 1'b0;
    if (second) xpad_nxt = 1'b1;
  end

  logic [3:0] waddr;
  assign waddr = (cmd.load_iv && cmd.take_word) ? 4'd0 : fill_r;

  assign sts.fill       = fill_r;
  assign sts.block_full = do_push && (waddr == 4'd15);
  assign sts.comp_last  = (rnd_r == 6'd63);
  assign sts.extra_pad  = xpad_r;

  // round logic
  logic [31:0] a, b, c, d, e, f, g, h, a12, ss1, ss2, ff, gg, tt1, tt2, tj, wn;
  logic        lo;
  always_comb begin
    a = rr_r[0]; b = rr_r[1]; c = rr_r[2]; d = rr_r[3];
    e = rr_r[4]; f = rr_r[5]; g = rr_r[6]; h = rr_r[7];
    lo  = (rnd_r < 6'd16);
    tj  = rotl(lo ? T_LOW : T_HIGH, rnd_r[4:0]);
    a12 = rotl(a, 5'd12);
    ss1 = rotl(a12 + e + tj, 5'd7);
    ss2 = ss1 ^ a12;
    ff  = lo ? (a ^ b ^ c) : ((a & b) | (a & c) | (b & c));
    gg  = lo ? (e ^ f ^ g) : ((e & f) | (~e & g));
    tt1 = ff + d + ss2 + (w_r[0] ^ w_r[4]);
    tt2 = gg + h + ss1 + w_r[0];
    wn  = perm1(w_r[0] ^ w_r[7] ^ rotl(w_r[13], 5'd15)) ^ rotl(w_r[3], 5'd7) ^ w_r[10];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      len_r  <= '0;
      xpad_r <= 1'b0;
      rnd_r  <= '0;
      for (int i = 0; i < 8; i++) cv_r[i] <= IV_RESET[255 - 32*i -: 32];
    end else begin
      fill_r <= fill_nxt;
      len_r  <= len_nxt;
      xpad_r <= xpad_nxt;
      if (cmd.load_iv)
        for (int i = 0; i < 8; i++) cv_r[i] <= iv[255 - 32*i -: 32];
      if (cmd.comp_start) begin
        rnd_r <= '0;
        for (int i = 0; i < 8; i++)
          rr_r[i] <= cmd.load_iv ? iv[255 - 32*i -: 32] : cv_r[i];
      end else if (cmd.comp_step) begin
        rnd_r <= rnd_r + 6'd1;
        rr_r[0] <= tt1;       rr_r[1] <= a;
        rr_r[2] <= rotl(b, 5'd9); rr_r[3] <= c;
        rr_r[4] <= perm0(tt2); rr_r[5] <= e;
        rr_r[6] <= rotl(f, 5'd19); rr_r[7] <= g;
        for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
        w_r[15] <= wn;
        if (rnd_r == 6'd63) begin
          cv_r[0] <= cv_r[0] ^ tt1;       cv_r[1] <= cv_r[1] ^ a;
          cv_r[2] <= cv_r[2] ^ rotl(b, 5'd9); cv_r[3] <= cv_r[3] ^ c;
          cv_r[4] <= cv_r[4] ^ perm0(tt2); cv_r[5] <= cv_r[5] ^ e;
          cv_r[6] <= cv_r[6] ^ rotl(f, 5'd19); cv_r[7] <= cv_r[7] ^ g;
        end
      end
    end
    if (do_push) w_r[waddr] <= push_val;
  end

  assign out_word = cv_r[out_idx];

endmodule
`default_nettype wire

@@ rtl/core/sm3_hash_engine.sv @@
`default_nettype none
// SM3 hash engine. Message words are taken one per cycle while a 16-word
// block fills; each full block then runs the 64-round compression, one
// round per cycle on a single round unit. The last word triggers padding,
// plus one more block when the length does not fit, and the digest
// leaves as eight words, index 0 most significant. The IV registers are
// sampled when the first word of a message is taken.
module sm3_hash_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] in_msg_word,
  input  wire logic [2:0]  in_byte_count,
  input  wire logic        in_last,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_digest_word,
  output logic [2:0]       out_word_index,
  output logic             out_last_word
);
  import sm3_pkg::*;

  logic [255:0] iv_r;
  sm3_cmd_t     cmd;
  sm3_sts_t     sts;
  logic [2:0]   oidx;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= IV_RESET;
    end else if (cfg_we) begin
      iv_r[255 - 32*cfg_index -: 32] <= cfg_data;
    end
  end

  sm3_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .in_last, .out_valid, .out_stall,
    .out_idx(oidx), .cmd, .sts
  );

  sm3_datapath u_dp (
    .clk, .rst_n, .iv(iv_r), .in_msg_word, .in_byte_count, .in_last,
    .out_idx(oidx), .out_word(out_digest_word), .cmd, .sts
  );

  assign out_word_index = oidx;
  assign out_last_word  = (oidx == 3'd7);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && !in_stall)) else $error("input open during output");
  a_out_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last_word |=> out_valid &&
    out_word_index == $past(out_word_index) + 3'd1) else $error("digest order");
  a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.take_word && cmd.push_pad)) else $error("double push");

endmodule
`default_nettype wire
